FILE: hw/rtl/bba_pkg.sv
package bba_pkg;

    // Heap geometry
    localparam int MIN_ORD = 5;
    localparam int MAX_ORD = 17;
    localparam int GRAN    = 4096;
    localparam int HDR     = 8;
    localparam int NORD    = MAX_ORD - MIN_ORD + 1;
    localparam int GW      = $clog2(GRAN);
    localparam int OW      = 5;
    localparam int SW      = $clog2(NORD);
    localparam int HSW     = 18;

    localparam logic [HSW-1:0] HEAP_CAP = HSW'(GRAN * (2 ** MIN_ORD));

    // Configuration register indexes
    localparam logic CFG_HEAP_BASE = 1'b0;
    localparam logic CFG_HEAP_LEN  = 1'b1;

    // Operation codes
    localparam logic [1:0] OPC_INIT  = 2'd0;
    localparam logic [1:0] OPC_ALLOC = 2'd1;
    localparam logic [1:0] OPC_FREE  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_LARGE = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NULL      = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;
    localparam logic [2:0] ST_DOUBLE    = 3'd5;

    typedef logic [GW-1:0] gidx_t;
    typedef logic [OW-1:0] ord_t;

    typedef struct packed {
        logic  ok;
        gidx_t idx;
    } link_t;

    typedef struct packed {
        logic free;
        ord_t level;
    } flev_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] request_size;
        logic [63:0] block_address;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_address;
        logic [2:0]  status;
    } out_item_t;

    typedef enum logic [4:0] {
        S_RCLR, S_IDLE, S_ICLR, S_IORD,
        S_ASIZE, S_AFIND, S_ATAKE, S_AUL,
        S_SPRD, S_SPUL, S_SPP1A, S_SPP1B, S_SPP2A, S_SPP2B,
        S_FOFF, S_FCHK, S_FST, S_FLOOP, S_FBUD, S_FPA, S_FPB,
        S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CLR, OP_LOAD, OP_I_ORD,
        OP_A_SIZE, OP_A_FIND, OP_A_TAKE, OP_A_UL,
        OP_SP_RD, OP_SP_UL, OP_PUSH_A, OP_PUSH_B,
        OP_F_OFF, OP_F_CHK, OP_F_ST, OP_F_LOOP, OP_F_BUD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       use_u;
        logic       fin;
        logic [2:0] code;
    } cmd_t;

    typedef struct packed {
        logic       cnt_last;
        logic       k_is_min;
        logic       too_large;
        logic       have_head;
        logic       found;
        logic       k_gt_tgt;
        logic       ptr_zero;
        logic       bad_off;
        logic       start_bit;
        logic       free_bit;
        logic       can_try;
        logic       merge;
        logic [1:0] in_op;
    } sts_t;

    // Free-list slot of an order
    function automatic logic [SW-1:0] slot(input ord_t k);
        return SW'(k - ord_t'(MIN_ORD));
    endfunction

endpackage

FILE: hw/rtl/bba_ram.sv
module bba_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic                 re,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];

    // One write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/bba_datapath.sv
module bba_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  bba_pkg::in_item_t   in_data,
    input  bba_pkg::cmd_t       cmd,
    output bba_pkg::sts_t       sts,
    output bba_pkg::out_item_t  out_data
);
    import bba_pkg::*;

    logic [63:0]     base_reg;
    logic [HSW-1:0]  size_reg;
    logic [32:0]     m_reg;
    logic [63:0]     ptr_reg;
    logic [63:0]     off_reg;
    logic [63:0]     addr_reg;
    gidx_t           g_reg;
    gidx_t           u_reg;
    gidx_t           cnt_reg;
    ord_t            k_reg;
    ord_t            tgt_reg;
    ord_t            largest_reg;
    logic [NORD-1:0] head_ok_reg;
    gidx_t           head_idx_reg [NORD];
    out_item_t       out_reg;

    logic [SW-1:0]   ks;
    gidx_t           head_k;
    logic            hok_k;
    gidx_t           y;
    logic [HSW-1:0]  eff;
    logic [32:0]     lim;
    ord_t            blen;
    ord_t            order;
    logic            found;
    ord_t            fk;
    logic [HSW-1:0]  boff;
    logic [GW:0]     bg;
    gidx_t           upper;
    logic            merge;

    logic            st_we, st_wd, st_re, st_rd;
    gidx_t           st_wa, st_ra;
    logic            fl_we;
    gidx_t           fl_wa;
    flev_t           fl_wd, fl_rd;
    logic            pv_we, nx_we, lk_re;
    gidx_t           pv_wa, nx_wa, lk_ra;
    link_t           pv_wd, nx_wd, prev_rd, next_rd;
    logic            head_we;
    link_t           head_wd;
    logic            unl_en;
    gidx_t           unl_x;

    // Metadata stores
    bba_ram #(.W(1), .D(GRAN)) u_start (
        .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
        .re(st_re), .raddr(st_ra), .rdata(st_rd)
    );
    bba_ram #(.W($bits(flev_t)), .D(GRAN)) u_flev (
        .clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
        .re(st_re), .raddr(st_ra), .rdata(fl_rd)
    );
    bba_ram #(.W($bits(link_t)), .D(GRAN)) u_prev (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .re(lk_re), .raddr(lk_ra), .rdata(prev_rd)
    );
    bba_ram #(.W($bits(link_t)), .D(GRAN)) u_next (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .re(lk_re), .raddr(lk_ra), .rdata(next_rd)
    );

    // Size, search and bounds arithmetic
    always_comb
    begin
        ks     = slot(k_reg);
        head_k = head_idx_reg[ks];
        hok_k  = head_ok_reg[ks];
        y      = cmd.use_u ? u_reg : g_reg;
        eff    = (size_reg >= HEAP_CAP) ? HEAP_CAP : size_reg;
        lim    = 33'(1) << largest_reg;

        blen = '0;
        for (int i = 0; i < HSW; i++)
        begin
            if (m_reg[i])
            begin
                blen = OW'(i + 1);
            end
        end
        order = (blen < ord_t'(MIN_ORD)) ? ord_t'(MIN_ORD) : blen;

        found = 1'b0;
        fk    = ord_t'(MIN_ORD);
        for (int i = NORD - 1; i >= 0; i--)
        begin
            if (head_ok_reg[i] && (OW'(i + MIN_ORD) > tgt_reg)
                && (OW'(i + MIN_ORD) <= largest_reg))
            begin
                found = 1'b1;
                fk    = OW'(i + MIN_ORD);
            end
        end

        boff  = off_reg[HSW-1:0] - HSW'(HDR);
        bg    = {1'b0, g_reg} ^ ((GW+1)'(1) << ks);
        upper = g_reg + (gidx_t'(1) << (ks - SW'(1)));
        merge = st_rd && fl_rd.free && (fl_rd.level == k_reg);
    end

    // Status to controller
    always_comb
    begin
        sts.cnt_last  = &cnt_reg;
        sts.k_is_min  = (k_reg == ord_t'(MIN_ORD));
        sts.too_large = (m_reg >= lim);
        sts.have_head = head_ok_reg[slot(tgt_reg)];
        sts.found     = found;
        sts.k_gt_tgt  = (k_reg > tgt_reg);
        sts.ptr_zero  = (ptr_reg == 64'd0);
        sts.bad_off   = (off_reg >= {{(64-HSW){1'b0}}, size_reg})
                        || (off_reg < 64'(HDR))
                        || (boff[MIN_ORD-1:0] != '0)
                        || (boff[HSW-1:MIN_ORD+GW] != '0);
        sts.start_bit = st_rd;
        sts.free_bit  = fl_rd.free;
        sts.can_try   = (k_reg < largest_reg) && !bg[GW]
                        && ({bg, {MIN_ORD{1'b0}}} < size_reg);
        sts.merge     = merge;
        sts.in_op     = in_data.operation;
    end

    // Store port steering
    always_comb
    begin
        st_we = 1'b0; st_wa = g_reg; st_wd = 1'b0;
        st_re = 1'b0; st_ra = g_reg;
        fl_we = 1'b0; fl_wa = g_reg; fl_wd = '0;
        pv_we = 1'b0; pv_wa = g_reg; pv_wd = '0;
        nx_we = 1'b0; nx_wa = g_reg; nx_wd = '0;
        lk_re = 1'b0; lk_ra = g_reg;
        head_we = 1'b0; head_wd = '0;
        unl_en = 1'b0; unl_x = g_reg;

        case (cmd.op)
            OP_CLR:
            begin
                st_we = 1'b1;
                st_wa = cnt_reg;
            end
            OP_I_ORD:
            begin
                if (eff[k_reg])
                begin
                    st_we   = 1'b1;
                    st_wd   = 1'b1;
                    fl_we   = 1'b1;
                    fl_wd   = '{free: 1'b1, level: k_reg};
                    pv_we   = 1'b1;
                    nx_we   = 1'b1;
                    nx_wd   = '{ok: hok_k, idx: head_k};
                    head_we = 1'b1;
                    head_wd = '{ok: 1'b1, idx: g_reg};
                end
            end
            OP_A_TAKE:
            begin
                lk_re = 1'b1;
                lk_ra = head_idx_reg[slot(tgt_reg)];
            end
            OP_SP_RD:
            begin
                lk_re = 1'b1;
                lk_ra = head_k;
            end
            OP_SP_UL:
            begin
                unl_en = 1'b1;
                st_we  = 1'b1;
                st_wa  = upper;
                st_wd  = 1'b1;
            end
            OP_A_UL:
            begin
                unl_en = 1'b1;
            end
            OP_PUSH_A:
            begin
                if (hok_k)
                begin
                    pv_we = 1'b1;
                    pv_wa = head_k;
                    pv_wd = '{ok: 1'b1, idx: y};
                end
            end
            OP_PUSH_B:
            begin
                fl_we   = 1'b1;
                fl_wa   = y;
                fl_wd   = '{free: 1'b1, level: k_reg};
                pv_we   = 1'b1;
                pv_wa   = y;
                nx_we   = 1'b1;
                nx_wa   = y;
                nx_wd   = '{ok: hok_k, idx: head_k};
                head_we = 1'b1;
                head_wd = '{ok: 1'b1, idx: y};
            end
            OP_F_CHK:
            begin
                st_re = 1'b1;
                st_ra = boff[MIN_ORD+GW-1:MIN_ORD];
            end
            OP_F_LOOP:
            begin
                st_re = 1'b1;
                st_ra = bg[GW-1:0];
                lk_re = 1'b1;
                lk_ra = bg[GW-1:0];
            end
            OP_F_BUD:
            begin
                if (merge)
                begin
                    unl_en = 1'b1;
                    unl_x  = u_reg;
                    st_we  = 1'b1;
                    st_wa  = (u_reg < g_reg) ? g_reg : u_reg;
                end
            end
            default:
            begin
            end
        endcase

        // Unlink from the order-k list
        if (unl_en)
        begin
            fl_we = 1'b1;
            fl_wa = unl_x;
            fl_wd = '{free: 1'b0, level: k_reg};
            if (next_rd.ok)
            begin
                pv_we = 1'b1;
                pv_wa = next_rd.idx;
                pv_wd = prev_rd;
            end
            if (prev_rd.ok)
            begin
                nx_we = 1'b1;
                nx_wa = prev_rd.idx;
                nx_wd = next_rd;
            end
            else
            begin
                head_we = 1'b1;
                head_wd = next_rd;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            size_reg    <= '0;
            head_ok_reg <= '0;
            largest_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_index)
                    CFG_HEAP_BASE: base_reg <= cfg_data;
                    default:       size_reg <= cfg_data[HSW-1:0];
                endcase
            end
            if (head_we)
            begin
                head_ok_reg[ks] <= head_wd.ok;
            end
            case (cmd.op)
                OP_CLR:
                begin
                    cnt_reg <= cnt_reg + gidx_t'(1);
                end
                OP_LOAD:
                begin
                    if (in_data.operation == OPC_INIT)
                    begin
                        head_ok_reg <= '0;
                        largest_reg <= '0;
                        cnt_reg     <= '0;
                    end
                end
                OP_I_ORD:
                begin
                    if (eff[k_reg] && (largest_reg < k_reg))
                    begin
                        largest_reg <= k_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_idx_reg[ks] <= head_wd.idx;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                m_reg    <= 33'(in_data.request_size) + 33'(HDR - 1);
                ptr_reg  <= in_data.block_address;
                addr_reg <= '0;
                g_reg    <= '0;
                k_reg    <= ord_t'(MAX_ORD);
            end
            OP_I_ORD:
            begin
                if (eff[k_reg])
                begin
                    g_reg <= g_reg + (gidx_t'(1) << ks);
                end
                k_reg <= k_reg - ord_t'(1);
            end
            OP_A_SIZE: tgt_reg <= order;
            OP_A_FIND: k_reg <= fk;
            OP_A_TAKE:
            begin
                g_reg <= head_idx_reg[slot(tgt_reg)];
                k_reg <= tgt_reg;
            end
            OP_SP_RD: g_reg <= head_k;
            OP_SP_UL:
            begin
                u_reg <= upper;
                k_reg <= k_reg - ord_t'(1);
            end
            OP_A_UL:
            begin
                addr_reg <= base_reg + {{(64-GW-MIN_ORD){1'b0}}, g_reg, {MIN_ORD{1'b0}}}
                            + 64'(HDR);
            end
            OP_F_OFF: off_reg <= ptr_reg - base_reg;
            OP_F_CHK: g_reg <= boff[MIN_ORD+GW-1:MIN_ORD];
            OP_F_ST:  k_reg <= fl_rd.level;
            OP_F_LOOP: u_reg <= bg[GW-1:0];
            OP_F_BUD:
            begin
                if (merge)
                begin
                    if (u_reg < g_reg)
                    begin
                        g_reg <= u_reg;
                    end
                    k_reg <= k_reg + ord_t'(1);
                end
            end
            default:
            begin
            end
        endcase
        if (cmd.fin)
        begin
            out_reg.result_address <= addr_reg;
            out_reg.status         <= cmd.code;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: hw/rtl/bba_ctrl.sv
module bba_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    input  bba_pkg::sts_t sts,
    output bba_pkg::cmd_t cmd
);
    import bba_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RCLR;
            code_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '{op: OP_NONE, use_u: 1'b0, fin: 1'b0, code: code_reg};
        in_stall   = 1'b1;

        unique case (state_reg)
            S_RCLR:
            begin
                cmd.op = OP_CLR;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    unique case (sts.in_op)
                        OPC_INIT:  state_next = S_ICLR;
                        OPC_ALLOC: state_next = S_ASIZE;
                        OPC_FREE:  state_next = S_FOFF;
                        default:
                        begin
                            code_next  = ST_INVALID;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ICLR:
            begin
                cmd.op = OP_CLR;
                if (sts.cnt_last)
                begin
                    state_next = S_IORD;
                end
            end
            S_IORD:
            begin
                cmd.op = OP_I_ORD;
                if (sts.k_is_min)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_ASIZE:
            begin
                if (sts.too_large)
                begin
                    code_next  = ST_TOO_LARGE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_A_SIZE;
                    state_next = S_AFIND;
                end
            end
            S_AFIND:
            begin
                cmd.op = OP_A_FIND;
                if (sts.have_head)
                begin
                    state_next = S_ATAKE;
                end
                else if (sts.found)
                begin
                    state_next = S_SPRD;
                end
                else
                begin
                    code_next  = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_ATAKE:
            begin
                cmd.op     = OP_A_TAKE;
                state_next = S_AUL;
            end
            S_AUL:
            begin
                cmd.op     = OP_A_UL;
                code_next  = ST_OK;
                state_next = S_DONE;
            end
            S_SPRD:
            begin
                cmd.op     = OP_SP_RD;
                state_next = S_SPUL;
            end
            S_SPUL:
            begin
                cmd.op     = OP_SP_UL;
                state_next = S_SPP1A;
            end
            S_SPP1A:
            begin
                cmd.op     = OP_PUSH_A;
                cmd.use_u  = 1'b1;
                state_next = S_SPP1B;
            end
            S_SPP1B:
            begin
                cmd.op     = OP_PUSH_B;
                cmd.use_u  = 1'b1;
                state_next = S_SPP2A;
            end
            S_SPP2A:
            begin
                cmd.op     = OP_PUSH_A;
                state_next = S_SPP2B;
            end
            S_SPP2B:
            begin
                cmd.op     = OP_PUSH_B;
                state_next = sts.k_gt_tgt ? S_SPRD : S_ATAKE;
            end
            S_FOFF:
            begin
                if (sts.ptr_zero)
                begin
                    code_next  = ST_NULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_F_OFF;
                    state_next = S_FCHK;
                end
            end
            S_FCHK:
            begin
                if (sts.bad_off)
                begin
                    code_next  = ST_INVALID;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_F_CHK;
                    state_next = S_FST;
                end
            end
            S_FST:
            begin
                if (!sts.start_bit)
                begin
                    code_next  = ST_INVALID;
                    state_next = S_DONE;
                end
                else if (sts.free_bit)
                begin
                    code_next  = ST_DOUBLE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_F_ST;
                    state_next = S_FLOOP;
                end
            end
            S_FLOOP:
            begin
                if (sts.can_try)
                begin
                    cmd.op     = OP_F_LOOP;
                    state_next = S_FBUD;
                end
                else
                begin
                    state_next = S_FPA;
                end
            end
            S_FBUD:
            begin
                cmd.op     = OP_F_BUD;
                state_next = sts.merge ? S_FLOOP : S_FPA;
            end
            S_FPA:
            begin
                cmd.op     = OP_PUSH_A;
                state_next = S_FPB;
            end
            S_FPB:
            begin
                cmd.op     = OP_PUSH_B;
                code_next  = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Output beat holds until taken
        if (cmd.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/buddy_block_allocator.sv
// Channel | Dir | Handshake          | Beat
// cfg     | in  | cfg_valid/ready    | cfg_index (0 heap_base, 1 heap length), cfg_data
// in      | in  | in_valid/in_stall  | in_data: operation, request_size, block_address
// out     | out | out_valid/out_stall| out_data: result_address, status
//
// One item at a time, walked by the controller over the metadata stores.
// Init: a sweep that clears the block-start store, then a pass over the orders from largest to smallest.
// Alloc: size check, list search, take and unlink, plus a read, an unlink and two pushes per order split.
// Free: offset and block-start checks, then a buddy read and merge per merge, then a push onto a list.
// After reset a clear of the block-start store holds in_stall high.
// A finished result waits in the output register; the next beat is taken meanwhile.
module buddy_block_allocator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  bba_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output bba_pkg::out_item_t  out_data
);
    import bba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd)
    );

    bba_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr(cfg_valid & cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
    );

`ifndef SYNTHESIS
    // Busy right after an accepted beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while busy");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (!out_valid || !out_stall))
        else $error("pending result overwritten");

    // Finished results carry a defined status
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> (cmd.code <= ST_DOUBLE))
        else $error("bad status code");
`endif

endmodule
